### rtl/wack_pkg.sv
package wack_pkg;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD       = 2'd1;
    localparam logic [1:0] STATUS_OUT_ORDER = 2'd2;

    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    localparam logic [1:0] REG_WINDOW_SIZE   = 2'd0;
    localparam logic [1:0] REG_SHORT_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_LONG_TIMEOUT  = 2'd2;

    localparam logic [7:0]  WINDOW_RESET        = 8'd16;
    localparam logic [15:0] SHORT_TIMEOUT_RESET = 16'd100;
    localparam logic [15:0] LONG_TIMEOUT_RESET  = 16'd1000;
    localparam logic [7:0]  SEQ_RESET           = 8'd255;

    typedef struct packed {
        logic [7:0]  window_size;
        logic [15:0] short_timeout;
        logic [15:0] long_timeout;
    } t_cfg;

endpackage

### rtl/wack_regs.sv
module wack_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output wack_pkg::t_cfg      o_cfg
);

    wack_pkg::t_cfg r_cfg;
    wack_pkg::t_cfg n_cfg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (paddr[3:2])
                wack_pkg::REG_WINDOW_SIZE:   n_cfg.window_size   = pwdata[7:0];
                wack_pkg::REG_SHORT_TIMEOUT: n_cfg.short_timeout = pwdata[15:0];
                wack_pkg::REG_LONG_TIMEOUT:  n_cfg.long_timeout  = pwdata[15:0];
                default:                     n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            wack_pkg::REG_WINDOW_SIZE:   prdata = {24'd0, r_cfg.window_size};
            wack_pkg::REG_SHORT_TIMEOUT: prdata = {16'd0, r_cfg.short_timeout};
            wack_pkg::REG_LONG_TIMEOUT:  prdata = {16'd0, r_cfg.long_timeout};
            default:                     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_size   <= wack_pkg::WINDOW_RESET;
            r_cfg.short_timeout <= wack_pkg::SHORT_TIMEOUT_RESET;
            r_cfg.long_timeout  <= wack_pkg::LONG_TIMEOUT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

### rtl/windowed_ack_receiver_core.sv
// Channel   Direction  Handshake          Payload
// request   in         i_valid / o_ready  i_kind i_decode_ok i_seq_num i_frag_first i_frag_last
// result    out        o_valid / i_ready  o_status o_deliver o_out_first o_out_last
//                                         o_ack_valid o_ack_seq o_ack_window
// config    in         APB psel/penable   paddr pwdata prdata pready
//
// Each request is decided in the cycle it is accepted and its result appears in the
// output register on the next cycle, one request per cycle sustained while results are read.
// The single output register sets the rate: a new request is taken whenever that
// register is empty or being read in the same cycle.
// Synchronous active-low reset sets the sequence state to 255, loads the timer with the
// long timeout and empties the output register.
module windowed_ack_receiver_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic        i_decode_ok,
    input  logic [7:0]  i_seq_num,
    input  logic        i_frag_first,
    input  logic        i_frag_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic        o_deliver,
    output logic        o_out_first,
    output logic        o_out_last,
    output logic        o_ack_valid,
    output logic [7:0]  o_ack_seq,
    output logic [7:0]  o_ack_window,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    wack_pkg::t_cfg cfg;

    logic [7:0]  r_last_recv;
    logic [7:0]  n_last_recv;
    logic [7:0]  r_last_acked;
    logic [7:0]  n_last_acked;
    logic [15:0] r_timer;
    logic [15:0] n_timer;

    logic        r_valid;
    logic [1:0]  r_status;
    logic [1:0]  n_status;
    logic        r_deliver;
    logic        n_deliver;
    logic        r_first;
    logic        n_first;
    logic        r_last;
    logic        n_last;
    logic        r_ack;
    logic        n_ack;
    logic [7:0]  r_ack_seq;
    logic [7:0]  n_ack_seq;
    logic [7:0]  r_ack_window;
    logic [7:0]  n_ack_window;

    logic        accept;
    logic [7:0]  unacked;

    wack_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign unacked = i_seq_num - r_last_acked;

    always_comb begin
        n_last_recv  = r_last_recv;
        n_last_acked = r_last_acked;
        n_timer      = r_timer;
        n_status     = wack_pkg::STATUS_OK;
        n_deliver    = 1'b0;
        n_first      = 1'b0;
        n_last       = 1'b0;
        n_ack        = 1'b0;
        n_ack_seq    = 8'd0;
        n_ack_window = 8'd0;
        if (i_kind == wack_pkg::KIND_TICK) begin
            if (r_timer <= 16'd1) begin
                // Expiry: everything received becomes acknowledged, so reload long.
                n_last_acked = r_last_recv;
                n_timer      = cfg.long_timeout;
                n_ack        = 1'b1;
                n_ack_seq    = r_last_recv;
                n_ack_window = cfg.window_size;
            end else begin
                n_timer = r_timer - 16'd1;
            end
        end else if (!i_decode_ok) begin
            n_status = wack_pkg::STATUS_BAD;
        end else if (i_seq_num != r_last_recv + 8'd1) begin
            n_status = wack_pkg::STATUS_OUT_ORDER;
        end else begin
            n_last_recv = i_seq_num;
            n_timer     = (i_seq_num == r_last_acked) ? cfg.long_timeout
                                                      : cfg.short_timeout;
            n_deliver   = 1'b1;
            n_first     = i_frag_first;
            n_last      = i_frag_last;
            if (i_frag_last || unacked >= {1'b0, cfg.window_size[7:1]}) begin
                n_last_acked = i_seq_num;
                n_timer      = cfg.long_timeout;
                n_ack        = 1'b1;
                n_ack_seq    = i_seq_num;
                n_ack_window = cfg.window_size;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_recv  <= wack_pkg::SEQ_RESET;
            r_last_acked <= wack_pkg::SEQ_RESET;
            r_timer      <= wack_pkg::LONG_TIMEOUT_RESET;
            r_valid      <= 1'b0;
        end else begin
            if (accept) begin
                r_last_recv  <= n_last_recv;
                r_last_acked <= n_last_acked;
                r_timer      <= n_timer;
                r_valid      <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status     <= n_status;
            r_deliver    <= n_deliver;
            r_first      <= n_first;
            r_last       <= n_last;
            r_ack        <= n_ack;
            r_ack_seq    <= n_ack_seq;
            r_ack_window <= n_ack_window;
        end
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_deliver    = r_deliver;
    assign o_out_first  = r_first;
    assign o_out_last   = r_last;
    assign o_ack_valid  = r_ack;
    assign o_ack_seq    = r_ack_seq;
    assign o_ack_window = r_ack_window;

    // A held result always matches the current state, so an ack names the acked sequence.
    a_ack_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_ack) |-> (r_ack_seq == r_last_acked))
        else $error("ack sequence differs from acknowledged state");

    a_reject_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_kind == wack_pkg::KIND_PACKET && n_status != wack_pkg::STATUS_OK)
        |=> ($stable(r_last_recv) && $stable(r_last_acked) && $stable(r_timer)))
        else $error("rejected packet changed receiver state");

    a_deliver_updates_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_deliver) |=> (r_last_recv == $past(i_seq_num) && r_deliver))
        else $error("delivered packet did not advance the sequence");

    a_ack_reloads_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_ack) |=> (r_timer == $past(cfg.long_timeout)
                               && r_last_acked == r_last_recv))
        else $error("ack did not reload the long timeout");

endmodule

### verif/windowed_ack_receiver_core_tb.sv
module windowed_ack_receiver_core_tb;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] status;
        logic       deliver;
        logic       out_first;
        logic       out_last;
        logic       ack_valid;
        logic [7:0] ack_seq;
        logic [7:0] ack_window;
    } t_rx_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_kind;
    logic        i_decode_ok;
    logic [7:0]  i_seq_num;
    logic        i_frag_first;
    logic        i_frag_last;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic        o_deliver;
    logic        o_out_first;
    logic        o_out_last;
    logic        o_ack_valid;
    logic [7:0]  o_ack_seq;
    logic [7:0]  o_ack_window;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Receiver model state, advanced once per accepted request.
    wack_pkg::t_cfg rx_cfg;
    logic [7:0]  rx_last_seq;
    logic [7:0]  rx_acked_seq;
    logic [15:0] rx_ack_timer;

    t_rx_outcome pending_outcomes[$];
    logic [7:0]  tx_next_seq;
    bit          calm;
    int unsigned mismatch_count;
    int unsigned cycle_count;

    windowed_ack_receiver_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_decode_ok  (i_decode_ok),
        .i_seq_num    (i_seq_num),
        .i_frag_first (i_frag_first),
        .i_frag_last  (i_frag_last),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_deliver    (o_deliver),
        .o_out_first  (o_out_first),
        .o_out_last   (o_out_last),
        .o_ack_valid  (o_ack_valid),
        .o_ack_seq    (o_ack_seq),
        .o_ack_window (o_ack_window),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_ready <= calm || ($urandom_range(99) >= 32);
    end

    // The timer reload depends on whether anything is still unacknowledged.
    function automatic void reload_ack_timer();
        if (rx_last_seq == rx_acked_seq) begin
            rx_ack_timer = rx_cfg.long_timeout;
        end else begin
            rx_ack_timer = rx_cfg.short_timeout;
        end
    endfunction

    function automatic void model_issue_ack(inout t_rx_outcome res);
        rx_acked_seq = rx_last_seq;
        reload_ack_timer();
        res.ack_valid  = 1'b1;
        res.ack_seq    = rx_last_seq;
        res.ack_window = rx_cfg.window_size;
    endfunction

    function automatic t_rx_outcome predict_outcome(logic kind, logic ok, logic [7:0] seq,
                                                    logic first, logic last);
        t_rx_outcome res;
        logic [7:0]  expected_seq;
        logic [7:0]  unacked;
        res = '0;
        expected_seq = rx_last_seq + 8'd1;
        if (kind == wack_pkg::KIND_TICK) begin
            if (rx_ack_timer <= 16'd1) begin
                model_issue_ack(res);
                rx_ack_timer = rx_cfg.long_timeout;
            end else begin
                rx_ack_timer = rx_ack_timer - 16'd1;
            end
        end else if (!ok) begin
            res.status = wack_pkg::STATUS_BAD;
        end else if (seq != expected_seq) begin
            res.status = wack_pkg::STATUS_OUT_ORDER;
        end else begin
            rx_last_seq = seq;
            reload_ack_timer();
            res.deliver   = 1'b1;
            res.out_first = first;
            res.out_last  = last;
            unacked = rx_last_seq - rx_acked_seq;
            if (last || unacked >= (rx_cfg.window_size >> 1)) begin
                model_issue_ack(res);
            end
        end
        return res;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rx_outcome want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_outcomes.size() == 0) begin
                $error("result with no request outstanding");
                mismatch_count++;
            end else begin
                want = pending_outcomes.pop_front();
                check_field("status", 8'(want.status), 8'(o_status));
                check_field("deliver", 8'(want.deliver), 8'(o_deliver));
                check_field("out_first", 8'(want.out_first), 8'(o_out_first));
                check_field("out_last", 8'(want.out_last), 8'(o_out_last));
                check_field("ack_valid", 8'(want.ack_valid), 8'(o_ack_valid));
                check_field("ack_seq", want.ack_seq, o_ack_seq);
                check_field("ack_window", want.ack_window, o_ack_window);
            end
        end
        if (i_rst_n && i_valid && o_ready) begin
            pending_outcomes.push_back(predict_outcome(i_kind, i_decode_ok, i_seq_num,
                                                       i_frag_first, i_frag_last));
        end
    end

    task automatic apb_write(logic [1:0] idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            wack_pkg::REG_WINDOW_SIZE:   rx_cfg.window_size   = data[7:0];
            wack_pkg::REG_SHORT_TIMEOUT: rx_cfg.short_timeout = data[15:0];
            wack_pkg::REG_LONG_TIMEOUT:  rx_cfg.long_timeout  = data[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic apb_read_check(logic [1:0] idx, logic [31:0] want, string name);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want) begin
            $error("%s readback: expected %0d, got %0d", name, want, prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_registers();
        apb_read_check(wack_pkg::REG_WINDOW_SIZE, {24'd0, rx_cfg.window_size}, "window_size");
        apb_read_check(wack_pkg::REG_SHORT_TIMEOUT, {16'd0, rx_cfg.short_timeout},
                       "short_timeout");
        apb_read_check(wack_pkg::REG_LONG_TIMEOUT, {16'd0, rx_cfg.long_timeout},
                       "long_timeout");
    endtask

    // Upper data bits are random; the block must keep only the register's width.
    task automatic write_config(logic [7:0] win, logic [15:0] short_to, logic [15:0] long_to);
        apb_write(wack_pkg::REG_WINDOW_SIZE, {24'($urandom), win});
        apb_write(wack_pkg::REG_SHORT_TIMEOUT, {16'($urandom), short_to});
        apb_write(wack_pkg::REG_LONG_TIMEOUT, {16'($urandom), long_to});
    endtask

    task automatic send_item(logic kind, logic ok, logic [7:0] seq, logic first, logic last);
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_decode_ok  <= ok;
        i_seq_num    <= seq;
        i_frag_first <= first;
        i_frag_last  <= last;
        if (kind == wack_pkg::KIND_PACKET && ok && seq == tx_next_seq) begin
            tx_next_seq = tx_next_seq + 8'd1;
        end
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic sender_gap();
        while (!calm && $urandom_range(99) < 32) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Blocks until every outstanding request has produced its result.
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic send_random_item();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 55) begin
            send_item(wack_pkg::KIND_PACKET, 1'b1, tx_next_seq, 1'($urandom),
                      $urandom_range(3) == 0);
        end else if (pick < 75) begin
            send_item(wack_pkg::KIND_TICK, 1'($urandom), 8'($urandom), 1'($urandom),
                      1'($urandom));
        end else if (pick < 87) begin
            send_item(wack_pkg::KIND_PACKET, 1'b0,
                      $urandom_range(1) ? tx_next_seq : 8'($urandom),
                      1'($urandom), 1'($urandom));
        end else begin
            send_item(wack_pkg::KIND_PACKET, 1'b1, tx_next_seq + 8'($urandom_range(255, 1)),
                      1'($urandom), 1'($urandom));
        end
    endtask

    task automatic test_reset_values();
        check_registers();
    endtask

    task automatic test_header_handling();
        int i;
        send_item(wack_pkg::KIND_TICK, 1'b1, 8'd255, 1'b1, 1'b1);
        send_item(wack_pkg::KIND_PACKET, 1'b0, 8'd0, 1'b1, 1'b1);
        send_item(wack_pkg::KIND_PACKET, 1'b1, 8'd5, 1'b0, 1'b0);
        send_item(wack_pkg::KIND_PACKET, 1'b1, 8'd255, 1'b1, 1'b1);
        send_item(wack_pkg::KIND_PACKET, 1'b1, 8'd0, 1'b1, 1'b0);
        send_item(wack_pkg::KIND_PACKET, 1'b1, 8'd1, 1'b0, 1'b1);
        // A repeated sequence number is out of order.
        send_item(wack_pkg::KIND_PACKET, 1'b1, 8'd1, 1'b0, 1'b1);
        send_item(wack_pkg::KIND_PACKET, 1'b0, 8'd2, 1'b0, 1'b0);
        // Eight unacknowledged packets reach half of the default window.
        for (i = 2; i < 10; i++) begin
            send_item(wack_pkg::KIND_PACKET, 1'b1, 8'(i), 1'b0, 1'b0);
        end
        send_item(wack_pkg::KIND_TICK, 1'b0, 8'd0, 1'b0, 1'b0);
        wait_results_drained();
    endtask

    task automatic test_timer_expiry();
        write_config(8'd16, 16'd1, 16'd2);
        send_item(wack_pkg::KIND_PACKET, 1'b1, tx_next_seq, 1'b0, 1'b0);
        send_item(wack_pkg::KIND_TICK, 1'b0, 8'd0, 1'b0, 1'b0);
        send_item(wack_pkg::KIND_TICK, 1'b1, 8'd255, 1'b1, 1'b1);
        send_item(wack_pkg::KIND_TICK, 1'b0, 8'd0, 1'b0, 1'b0);
        send_item(wack_pkg::KIND_TICK, 1'b0, 8'd0, 1'b0, 1'b0);
        wait_results_drained();
    endtask

    task automatic test_ignored_register();
        apb_write(REG_UNUSED, $urandom);
        check_registers();
    endtask

    task automatic run_phase(logic [7:0] win, logic [15:0] short_to, logic [15:0] long_to,
                             int count, bit no_idle);
        int i;
        wait_results_drained();
        write_config(win, short_to, long_to);
        check_registers();
        calm = no_idle;
        for (i = 0; i < count; i++) begin
            sender_gap();
            send_random_item();
            if (i == count / 2) begin
                wait_results_drained();
            end
        end
        wait_results_drained();
        calm = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_phase(8'd0, 16'd1, 16'd1, 150, 1'b0);
        run_phase(8'd1, 16'd3, 16'd7, 150, 1'b0);
        run_phase(8'd255, 16'd65535, 16'd65535, 150, 1'b0);
        run_phase(8'($urandom_range(40, 2)), 16'($urandom_range(20, 1)),
                  16'($urandom_range(40, 1)), 200, 1'b0);
        // A zero reload behaves as one tick.
        run_phase(8'd16, 16'd0, 16'd2, 100, 1'b0);
        run_phase(8'($urandom), 16'($urandom_range(12, 1)), 16'($urandom_range(30, 1)),
                  320, 1'b1);
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_kind         <= wack_pkg::KIND_PACKET;
        i_decode_ok    <= 1'b0;
        i_seq_num      <= 8'd0;
        i_frag_first   <= 1'b0;
        i_frag_last    <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= 4'd0;
        pwdata         <= 32'd0;
        calm           = 1'b0;
        mismatch_count = 0;
        tx_next_seq    = wack_pkg::SEQ_RESET + 8'd1;
        rx_cfg.window_size   = wack_pkg::WINDOW_RESET;
        rx_cfg.short_timeout = wack_pkg::SHORT_TIMEOUT_RESET;
        rx_cfg.long_timeout  = wack_pkg::LONG_TIMEOUT_RESET;
        rx_last_seq    = wack_pkg::SEQ_RESET;
        rx_acked_seq   = wack_pkg::SEQ_RESET;
        rx_ack_timer   = wack_pkg::LONG_TIMEOUT_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_header_handling();
        test_timer_expiry();
        test_ignored_register();
        test_random_traffic();

        wait_results_drained();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### files.f
rtl/wack_pkg.sv
rtl/wack_regs.sv
rtl/windowed_ack_receiver_core.sv
verif/windowed_ack_receiver_core_tb.sv
